// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// implication or plain property, disabled during reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition that must never hold out of reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== rtl/scdl_pkg.sv =====
// ---------------------------------------------------------------------------
// scdl_pkg
// Widths and types shared by the segment distance pipeline.
// ---------------------------------------------------------------------------
package scdl_pkg;

  localparam int CW        = 24;      // coordinate width
  localparam int NFIELD    = 12;      // coordinates per beat
  localparam int DFW       = CW + 1;  // u, v, w components
  localparam int PRW       = 2 * DFW; // component products
  localparam int DOTW      = PRW + 2; // dot products
  localparam int WW        = 108;     // determinant and numerators
  localparam int MW        = 60;      // multiplier operand
  localparam int MPW       = 2 * MW;  // multiplier product
  localparam int PF        = 32;      // parameter fraction bits
  localparam int QW        = PF + 1;  // parameter, 0 .. 2^32
  localparam int CMPW      = 59;      // dP component
  localparam int SQW       = 64;      // root operand
  localparam int RW        = 32;      // root result
  localparam int OW        = CW + 1;  // distance field
  localparam int THW       = 64;      // threshold register
  localparam int DIV_STEPS = PF;
  localparam int SQ_STEPS  = SQW / 2;

  typedef logic signed [DFW-1:0]  dif_t;
  typedef logic signed [DOTW-1:0] dot_t;
  typedef logic signed [WW-1:0]   wide_t;
  typedef logic signed [MW-1:0]   mop_t;
  typedef logic signed [MPW-1:0]  mprod_t;

  typedef struct packed {
    dif_t [2:0] u;
    dif_t [2:0] v;
    dif_t [2:0] w;
  } uvw_t;

  typedef struct packed {
    dot_t a;
    dot_t b;
    dot_t c;
    dot_t d;
    dot_t e;
  } dots_t;

  typedef struct packed {
    wide_t sn;
    wide_t sd;
    wide_t tn;
    wide_t td;
  } frac_t;

endpackage

// ===== rtl/segment_closest_distance_3d_top.sv =====
// ---------------------------------------------------------------------------
// segment_closest_distance_3d_top
// Shortest distance between two 3D segments, fully pipelined.
// ---------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/tready     12 x 24-bit signed coordinates
//  out_     out  out_tvalid/tready    25-bit distance, integer, no fraction bits
//  cfg_     in   cfg_valid/ready      64-bit parallel threshold
//
//  One beat enters per cycle while the output is not stalled; the depth is set
//  by the 33-stage parameter dividers and the 33-stage root pipeline.
//  All stages share one advance enable; a stalled output freezes the whole
//  pipeline, so no beat is dropped or repeated.
//  rst_n clears valid bits and the threshold; payload is not reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_closest_distance_3d_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // first_start_x/y/z, first_end_x/y/z, second_start_x/y/z, second_end_x/y/z
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // closest_distance [24:0], zero pad [31:25]
  output logic [31:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [63:0]  cfg_data
);

  localparam int CW   = scdl_pkg::CW;
  localparam int DFW  = scdl_pkg::DFW;
  localparam int PRW  = scdl_pkg::PRW;
  localparam int DOTW = scdl_pkg::DOTW;
  localparam int WW   = scdl_pkg::WW;
  localparam int MW   = scdl_pkg::MW;
  localparam int MPW  = scdl_pkg::MPW;
  localparam int PF   = scdl_pkg::PF;
  localparam int QW   = scdl_pkg::QW;
  localparam int CMPW = scdl_pkg::CMPW;
  localparam int SQW  = scdl_pkg::SQW;
  localparam int RW   = scdl_pkg::RW;
  localparam int OW   = scdl_pkg::OW;
  localparam int THW  = scdl_pkg::THW;
  localparam int SUMW = MPW + 2;
  localparam int DLAT = scdl_pkg::DIV_STEPS + 1;

  logic adv;
  logic [THW-1:0] thr_r;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  // valid chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r;
  logic v10_r, v11_r, v12_r, v13_r, v14_r, out_valid_r;
  logic sc_vo, tc_vo, sq_vo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r} <= '0;
      {v10_r, v11_r, v12_r, v13_r, v14_r, out_valid_r}       <= '0;
    end else if (adv) begin
      v1_r  <= in_tvalid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= sc_vo;
      v11_r <= v10_r;
      v12_r <= v11_r;
      v13_r <= v12_r;
      v14_r <= v13_r;
      out_valid_r <= sq_vo;
    end
  end

  // stage 1: edge and offset vectors
  scdl_pkg::uvw_t uvw1_nxt, uvw1_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      uvw1_nxt.u[k] = DFW'($signed(in_tdata[(3 + k) * CW +: CW]))
                    - DFW'($signed(in_tdata[k * CW +: CW]));
      uvw1_nxt.v[k] = DFW'($signed(in_tdata[(9 + k) * CW +: CW]))
                    - DFW'($signed(in_tdata[(6 + k) * CW +: CW]));
      uvw1_nxt.w[k] = DFW'($signed(in_tdata[k * CW +: CW]))
                    - DFW'($signed(in_tdata[(6 + k) * CW +: CW]));
    end
  end

  // stage 2: component products (uu, uv, vv, uw, vw)
  logic signed [PRW-1:0] pr_nxt [5][3];
  logic signed [PRW-1:0] pr_r   [5][3];
  scdl_pkg::uvw_t uvw2_r, uvw3_r, uvw4_r, uvw5_r, uvw6_r, uvw7_r, uvw8_r, uvw9_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pr_nxt[0][k] = $signed(uvw1_r.u[k]) * $signed(uvw1_r.u[k]);
      pr_nxt[1][k] = $signed(uvw1_r.u[k]) * $signed(uvw1_r.v[k]);
      pr_nxt[2][k] = $signed(uvw1_r.v[k]) * $signed(uvw1_r.v[k]);
      pr_nxt[3][k] = $signed(uvw1_r.u[k]) * $signed(uvw1_r.w[k]);
      pr_nxt[4][k] = $signed(uvw1_r.v[k]) * $signed(uvw1_r.w[k]);
    end
  end

  // stage 3: dot products
  scdl_pkg::dots_t dots3_nxt, dots3_r, dots4_r, dots5_r, dots6_r, dots7_r, dots8_r;

  always_comb begin
    dots3_nxt.a = DOTW'(pr_r[0][0]) + DOTW'(pr_r[0][1]) + DOTW'(pr_r[0][2]);
    dots3_nxt.b = DOTW'(pr_r[1][0]) + DOTW'(pr_r[1][1]) + DOTW'(pr_r[1][2]);
    dots3_nxt.c = DOTW'(pr_r[2][0]) + DOTW'(pr_r[2][1]) + DOTW'(pr_r[2][2]);
    dots3_nxt.d = DOTW'(pr_r[3][0]) + DOTW'(pr_r[3][1]) + DOTW'(pr_r[3][2]);
    dots3_nxt.e = DOTW'(pr_r[4][0]) + DOTW'(pr_r[4][1]) + DOTW'(pr_r[4][2]);
  end

  // stages 4-5: cross products of dots
  scdl_pkg::mprod_t ac_p, bb_p, be_p, cd_p, ae_p, bd_p;

  scdl_mul u_mul_ac (.clk(clk), .en(adv), .op_a(MW'(dots3_r.a)), .op_b(MW'(dots3_r.c)),
                     .prod(ac_p));
  scdl_mul u_mul_bb (.clk(clk), .en(adv), .op_a(MW'(dots3_r.b)), .op_b(MW'(dots3_r.b)),
                     .prod(bb_p));
  scdl_mul u_mul_be (.clk(clk), .en(adv), .op_a(MW'(dots3_r.b)), .op_b(MW'(dots3_r.e)),
                     .prod(be_p));
  scdl_mul u_mul_cd (.clk(clk), .en(adv), .op_a(MW'(dots3_r.c)), .op_b(MW'(dots3_r.d)),
                     .prod(cd_p));
  scdl_mul u_mul_ae (.clk(clk), .en(adv), .op_a(MW'(dots3_r.a)), .op_b(MW'(dots3_r.e)),
                     .prod(ae_p));
  scdl_mul u_mul_bd (.clk(clk), .en(adv), .op_a(MW'(dots3_r.b)), .op_b(MW'(dots3_r.d)),
                     .prod(bd_p));

  // stage 6: determinant and raw numerators
  scdl_pkg::wide_t det_r, sn6_r, tn6_r;

  // stage 7: parallel test and first clamp of sc
  scdl_pkg::frac_t fr7_nxt, fr7_r;

  always_comb begin
    logic par;
    par = det_r[WW-1] || (det_r == '0)
       || ((det_r[WW-1:THW] == '0) && (det_r[THW-1:0] <= thr_r));
    if (par) begin
      fr7_nxt.sn = '0;
      fr7_nxt.sd = WW'(1);
      fr7_nxt.tn = WW'(dots6_r.e);
      fr7_nxt.td = WW'(dots6_r.c);
    end else begin
      fr7_nxt.sn = sn6_r;
      fr7_nxt.sd = det_r;
      fr7_nxt.tn = tn6_r;
      fr7_nxt.td = det_r;
      if (sn6_r[WW-1]) begin
        fr7_nxt.sn = '0;
        fr7_nxt.tn = WW'(dots6_r.e);
        fr7_nxt.td = WW'(dots6_r.c);
      end else if (sn6_r > det_r) begin
        fr7_nxt.sn = det_r;
        fr7_nxt.tn = WW'(dots6_r.e) + WW'(dots6_r.b);
        fr7_nxt.td = WW'(dots6_r.c);
      end
    end
  end

  // stage 8: clamp tc, pick the sc recompute numerator
  scdl_pkg::frac_t fr8_nxt, fr8_r;
  logic signed [DOTW:0] nd_nxt, nd_r;
  logic adj_nxt, adj_r;

  always_comb begin
    fr8_nxt = fr7_r;
    nd_nxt  = '0;
    adj_nxt = 1'b0;
    if (fr7_r.tn[WW-1] || (fr7_r.tn == '0)) begin
      fr8_nxt.tn = '0;
      nd_nxt     = -(DOTW + 1)'(dots7_r.d);
      adj_nxt    = 1'b1;
    end else if (fr7_r.tn > fr7_r.td) begin
      fr8_nxt.tn = fr7_r.td;
      nd_nxt     = (DOTW + 1)'(dots7_r.b) - (DOTW + 1)'(dots7_r.d);
      adj_nxt    = 1'b1;
    end
  end

  // stage 9: recompute sc against the clamped tc
  scdl_pkg::frac_t fr9_nxt, fr9_r;

  always_comb begin
    fr9_nxt = fr8_r;
    if (adj_r) begin
      if (nd_r[DOTW]) begin
        fr9_nxt.sn = '0;
      end else if (nd_r > (DOTW + 1)'(dots8_r.a)) begin
        fr9_nxt.sn = fr8_r.sd;
      end else begin
        fr9_nxt.sn = WW'(nd_r);
        fr9_nxt.sd = WW'(dots8_r.a);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      uvw1_r  <= uvw1_nxt;
      uvw2_r  <= uvw1_r;
      pr_r    <= pr_nxt;
      uvw3_r  <= uvw2_r;
      dots3_r <= dots3_nxt;
      uvw4_r  <= uvw3_r;
      dots4_r <= dots3_r;
      uvw5_r  <= uvw4_r;
      dots5_r <= dots4_r;
      uvw6_r  <= uvw5_r;
      dots6_r <= dots5_r;
      det_r   <= WW'(ac_p) - WW'(bb_p);
      sn6_r   <= WW'(be_p) - WW'(cd_p);
      tn6_r   <= WW'(ae_p) - WW'(bd_p);
      uvw7_r  <= uvw6_r;
      dots7_r <= dots6_r;
      fr7_r   <= fr7_nxt;
      uvw8_r  <= uvw7_r;
      dots8_r <= dots7_r;
      fr8_r   <= fr8_nxt;
      nd_r    <= nd_nxt;
      adj_r   <= adj_nxt;
      uvw9_r  <= uvw8_r;
      fr9_r   <= fr9_nxt;
    end
  end

  // parameter dividers, vectors ride alongside
  logic [QW-1:0] sc, tc;
  scdl_pkg::uvw_t uvw_dl_r [DLAT];

  scdl_div u_div_s (.clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v9_r),
                    .num(fr9_r.sn), .den(fr9_r.sd), .out_valid(sc_vo), .quo(sc));
  scdl_div u_div_t (.clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v9_r),
                    .num(fr9_r.tn), .den(fr9_r.td), .out_valid(tc_vo), .quo(tc));

  always_ff @(posedge clk) begin
    if (adv) begin
      uvw_dl_r[0] <= uvw9_r;
      for (int i = 1; i < DLAT; i++) begin
        uvw_dl_r[i] <= uvw_dl_r[i-1];
      end
    end
  end

  // stage 10: sc*u, tc*v, w scaled; stage 11: dP components
  logic signed [CMPW-1:0] pu_nxt [3], pv_nxt [3], ww_nxt [3];
  logic signed [CMPW-1:0] pu_r [3], pv_r [3], ww_r [3];
  logic signed [CMPW-1:0] comp_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pu_nxt[k] = $signed({1'b0, sc}) * $signed(uvw_dl_r[DLAT-1].u[k]);
      pv_nxt[k] = $signed({1'b0, tc}) * $signed(uvw_dl_r[DLAT-1].v[k]);
      ww_nxt[k] = CMPW'($signed(uvw_dl_r[DLAT-1].w[k])) <<< PF;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        pu_r[k]   <= pu_nxt[k];
        pv_r[k]   <= pv_nxt[k];
        ww_r[k]   <= ww_nxt[k];
        comp_r[k] <= ww_r[k] + pu_r[k] - pv_r[k];
      end
    end
  end

  // stages 12-13: squares
  scdl_pkg::mprod_t sq_p [3];

  for (genvar k = 0; k < 3; k++) begin : g_sq
    scdl_mul u_mul_sq (.clk(clk), .en(adv), .op_a(MW'(comp_r[k])), .op_b(MW'(comp_r[k])),
                       .prod(sq_p[k]));
  end

  // stage 14: sum of squares, keep the integer part of the 2^64 scale
  logic [SUMW-1:0] sum_sq;
  logic [SQW-1:0]  sq_in_r;

  always_comb begin
    sum_sq = SUMW'(unsigned'(sq_p[0])) + SUMW'(unsigned'(sq_p[1]))
           + SUMW'(unsigned'(sq_p[2]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_in_r <= SQW'(sum_sq[SUMW-1:SQW]);
    end
  end

  logic [RW-1:0] root;
  logic [OW-1:0] dist_r;

  scdl_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v14_r),
                    .rad(sq_in_r), .out_valid(sq_vo), .root(root));

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_r <= root[OW-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(32 - OW){1'b0}}, dist_r};

  `ASSERT_CLK(a_div_lockstep, clk, rst_n, sc_vo == tc_vo, "divider lanes out of step")
  `ASSERT_NEVER(a_param_range, clk, rst_n,
                sc_vo && ((sc > (QW'(1) << PF)) || (tc > (QW'(1) << PF))),
                "segment parameter above one")
  `ASSERT_CLK(a_stall_hold, clk, rst_n, !in_tready |=> $stable(sq_in_r) && $stable(v14_r),
              "pipeline moved during stall")

endmodule

// ===== rtl/scdl_mul.sv =====
// ---------------------------------------------------------------------------
// scdl_mul
// Two-stage signed multiplier built from four half-width partial products.
// ---------------------------------------------------------------------------
module scdl_mul (
  input  logic                   clk,
  input  logic                   en,
  input  scdl_pkg::mop_t         op_a,
  input  scdl_pkg::mop_t         op_b,
  output scdl_pkg::mprod_t       prod
);

  localparam int MW  = scdl_pkg::MW;
  localparam int MPW = scdl_pkg::MPW;
  localparam int H   = MW / 2;

  logic [MW-1:0]  mag_a, mag_b;
  logic           neg;
  logic [MW-1:0]  pp_r [4];
  logic           neg_r;
  logic [MPW-1:0] mag_sum;
  logic [MPW-1:0] prod_r;

  always_comb begin
    mag_a = op_a[MW-1] ? MW'(-op_a) : MW'(op_a);
    mag_b = op_b[MW-1] ? MW'(-op_b) : MW'(op_b);
    neg   = op_a[MW-1] ^ op_b[MW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r[0] <= mag_a[H-1:0]  * mag_b[H-1:0];
      pp_r[1] <= mag_a[H-1:0]  * mag_b[MW-1:H];
      pp_r[2] <= mag_a[MW-1:H] * mag_b[H-1:0];
      pp_r[3] <= mag_a[MW-1:H] * mag_b[MW-1:H];
      neg_r   <= neg;
    end
  end

  always_comb begin
    mag_sum = MPW'(pp_r[0]) + (MPW'(pp_r[1]) << H) + (MPW'(pp_r[2]) << H)
            + (MPW'(pp_r[3]) << MW);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= neg_r ? -mag_sum : mag_sum;
    end
  end

  assign prod = $signed(prod_r);

endmodule

// ===== rtl/scdl_div.sv =====
// ---------------------------------------------------------------------------
// scdl_div
// Pipelined fraction divider: floor(num * 2^32 / den), one quotient bit a
// stage, with zero and saturate cases flagged at entry.
// ---------------------------------------------------------------------------
module scdl_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  scdl_pkg::wide_t          num,
  input  scdl_pkg::wide_t          den,
  output logic                     out_valid,
  output logic [scdl_pkg::QW-1:0]  quo
);

  localparam int WW = scdl_pkg::WW;
  localparam int PF = scdl_pkg::PF;
  localparam int QW = scdl_pkg::QW;
  localparam int N  = scdl_pkg::DIV_STEPS;

  logic [N:0]    v_r;
  logic          zero_r [N+1];
  logic          full_r [N+1];
  logic [WW-1:0] rem_r [N+1];
  logic [WW-1:0] den_r [N+1];
  logic [PF-1:0] q_r   [N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= WW'(num);
      den_r[0]  <= WW'(den);
      q_r[0]    <= '0;
      zero_r[0] <= (num <= 0) || (den <= 0);
      full_r[0] <= num >= den;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [WW:0] rem2;
    logic [WW:0] diff;
    logic        ge;

    always_comb begin
      rem2 = {rem_r[k-1], 1'b0};
      diff = rem2 - {1'b0, den_r[k-1]};
      ge   = rem2 >= {1'b0, den_r[k-1]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[WW-1:0] : rem2[WW-1:0];
        den_r[k]  <= den_r[k-1];
        q_r[k]    <= {q_r[k-1][PF-2:0], ge};
        zero_r[k] <= zero_r[k-1];
        full_r[k] <= full_r[k-1];
      end
    end
  end

  always_comb begin
    if (zero_r[N]) begin
      quo = '0;
    end else if (full_r[N]) begin
      quo = QW'(1) << PF;
    end else begin
      quo = {1'b0, q_r[N]};
    end
  end

  assign out_valid = v_r[N];

endmodule

// ===== rtl/scdl_sqrt.sv =====
// ---------------------------------------------------------------------------
// scdl_sqrt
// Pipelined integer square root of a 64-bit value, one result bit a stage.
// ---------------------------------------------------------------------------
module scdl_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [scdl_pkg::SQW-1:0]  rad,
  output logic                      out_valid,
  output logic [scdl_pkg::RW-1:0]   root
);

  localparam int SQW = scdl_pkg::SQW;
  localparam int RW  = scdl_pkg::RW;
  localparam int N   = scdl_pkg::SQ_STEPS;

  logic [N:0]     v_r;
  logic [SQW-1:0] rad_r [N+1];
  logic [SQW-1:0] res_r [N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0] <= rad;
      res_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_step
    localparam logic [SQW-1:0] BIT_K = SQW'(1) << (SQW - 2 * k);
    logic [SQW-1:0] trial;
    logic           ge;

    always_comb begin
      trial = res_r[k-1] + BIT_K;
      ge    = rad_r[k-1] >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k] <= ge ? rad_r[k-1] - trial : rad_r[k-1];
        res_r[k] <= ge ? (res_r[k-1] >> 1) + BIT_K : res_r[k-1] >> 1;
      end
    end
  end

  assign root      = res_r[N][RW-1:0];
  assign out_valid = v_r[N];

endmodule
